FILE: rtl/core/obps_pkg.sv
`timescale 1ns / 1ps

package obps_pkg;

	localparam int LIM_W     = 20;
	localparam int CNT_W     = 17;
	localparam int MAX_LIMIT = 1048576;
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int MEM_DEPTH = MAX_LIMIT / (2 * WORD_BITS);
	localparam int WADDR_W   = $clog2(MEM_DEPTH);
	localparam int NBYTES    = WORD_BITS / 8;
	localparam int SUM_W     = BIT_W + 1;
	localparam int P_W       = 11;
	localparam int J_W       = LIM_W + 1;
	localparam int LIST_LEN  = 10;
	localparam int K_W       = 4;
	localparam int APB_AW    = 2;
	localparam int APB_DW    = 32;

	localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(1000);
	localparam logic [APB_AW-1:0] REG_LIMIT   = '0;

	localparam logic [1:0] CMD_SIEVE = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_LIST  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_P_SQ,
		ST_P_CHK,
		ST_P_RD,
		ST_M_RD,
		ST_M_WR,
		ST_COUNT,
		ST_DRAIN,
		ST_Q_RD,
		ST_L_RD,
		ST_L_CHK,
		ST_L_TWO,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_P,
		RD_J,
		RD_W
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_MARK
	} wr_sel_t;

	typedef struct packed {
		logic    accept;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    p_inc;
		logic    j_ld_sq;
		logic    j_step;
		logic    j_dec;
		logic    w_inc;
		logic    cnt_init;
		logic    cnt_issue;
		logic    list_take;
		logic    take_two;
		logic    out_mid;
		logic    out_final;
	} dp_cmd_t;

	typedef struct packed {
		logic sieve_done;
		logic sq_gt_lim;
		logic p_marked;
		logic j_gt_lim;
		logic j_lt3;
		logic j_marked;
		logic w_last;
		logic cnt_busy;
		logic out_free;
		logic k_last;
		logic pend;
		logic lim_ge2;
	} dp_stat_t;

	function automatic logic [3:0] popcnt8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'b000, b[k]};
		end
		return n;
	endfunction

endpackage

FILE: rtl/core/obps_req_if.sv
`timescale 1ns / 1ps

interface obps_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [obps_pkg::LIM_W-1:0] number;

	modport source(output valid, output cmd, output number, input ready);
	modport sink(input valid, input cmd, input number, output ready);
endinterface

FILE: rtl/core/obps_res_if.sv
`timescale 1ns / 1ps

interface obps_res_if;
	logic                       valid;
	logic                       ready;
	logic                       valid_res;
	logic                       is_prime;
	logic [obps_pkg::LIM_W-1:0] prime_value;
	logic [obps_pkg::CNT_W-1:0] prime_count;
	logic                       last;

	modport source(output valid, output valid_res, output is_prime, output prime_value,
		output prime_count, output last, input ready);
	modport sink(input valid, input valid_res, input is_prime, input prime_value,
		input prime_count, input last, output ready);
endinterface

FILE: rtl/core/obps_cfg.sv
`timescale 1ns / 1ps

module obps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [obps_pkg::APB_AW-1:0] paddr,
	input  logic [obps_pkg::APB_DW-1:0] pwdata,
	output logic [obps_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [obps_pkg::LIM_W-1:0]  lim,
	output logic                        wr
);

	// Even limits other than zero are pulled down to the odd number below them.
	function automatic logic [obps_pkg::LIM_W-1:0] eff_limit(
		input logic [obps_pkg::LIM_W-1:0] v);
		logic [obps_pkg::LIM_W-1:0] r;
		r = v;
		if (!v[0] && v != '0) begin
			r = v - obps_pkg::LIM_W'(1);
		end
		return r;
	endfunction

	logic [obps_pkg::LIM_W-1:0] limit_q;
	logic [obps_pkg::LIM_W-1:0] lim_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready & (paddr == obps_pkg::REG_LIMIT);
	assign lim    = lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= obps_pkg::LIMIT_RESET;
			lim_q   <= eff_limit(obps_pkg::LIMIT_RESET);
		end else if (wr) begin
			limit_q <= pwdata[obps_pkg::LIM_W-1:0];
			lim_q   <= eff_limit(pwdata[obps_pkg::LIM_W-1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == obps_pkg::REG_LIMIT) begin
			prdata = {{(obps_pkg::APB_DW - obps_pkg::LIM_W){1'b0}}, limit_q};
		end
	end

endmodule

FILE: rtl/core/obps_datapath.sv
`timescale 1ns / 1ps

module obps_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  obps_pkg::dp_cmd_t          cmd,
	output obps_pkg::dp_stat_t         stat,
	input  logic [1:0]                 req_cmd,
	input  logic [obps_pkg::LIM_W-1:0] req_number,
	input  logic [obps_pkg::LIM_W-1:0] lim,
	input  logic                       cfg_wr,
	obps_res_if.source                 res
);

	localparam int LIM_W     = obps_pkg::LIM_W;
	localparam int CNT_W     = obps_pkg::CNT_W;
	localparam int WORD_BITS = obps_pkg::WORD_BITS;
	localparam int BIT_W     = obps_pkg::BIT_W;
	localparam int WADDR_W   = obps_pkg::WADDR_W;
	localparam int NBYTES    = obps_pkg::NBYTES;
	localparam int SUM_W     = obps_pkg::SUM_W;
	localparam int P_W       = obps_pkg::P_W;
	localparam int J_W       = obps_pkg::J_W;
	localparam int K_W       = obps_pkg::K_W;
	localparam int PWORD_W   = P_W - BIT_W - 1;

	logic [WORD_BITS-1:0] mem_q [obps_pkg::MEM_DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	logic [P_W-1:0]     p_q;
	logic [2*P_W-1:0]   sq_full;
	logic [J_W-1:0]     sq_s1;
	logic [J_W-1:0]     j_q;
	logic [WADDR_W-1:0] w_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sieve_done_q;
	logic [1:0]         cmd_q;
	logic               pend_q;
	logic [LIM_W-1:0]   pend_val_q;
	logic [K_W-1:0]     k_q;

	logic               cv_s1;
	logic               cv_s2;
	logic [WADDR_W-1:0] cw_s1;
	logic [3:0]         bc_s2 [NBYTES];
	logic [3:0]         bc    [NBYTES];
	logic [SUM_W-1:0]   bsum;

	logic [WADDR_W-1:0] hw;
	logic [BIT_W-1:0]   hb;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] zeros;

	logic [WADDR_W-1:0]   raddr;
	logic [WADDR_W-1:0]   waddr;
	logic [WADDR_W-1:0]   j_word;
	logic [WADDR_W-1:0]   p_word;
	logic [WORD_BITS-1:0] wdata;
	logic                 re;
	logic                 we;
	logic                 q_prime;

	logic               out_valid_q;
	logic               out_valid_res_q;
	logic               out_is_prime_q;
	logic [LIM_W-1:0]   out_value_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_last_q;
	logic               nx_valid_res;
	logic               nx_is_prime;
	logic [LIM_W-1:0]   nx_value;
	logic [CNT_W-1:0]   nx_count;
	logic               nx_last;

	assign hw     = lim[LIM_W-1:BIT_W+1];
	assign hb     = lim[BIT_W:1];
	assign j_word = j_q[BIT_W+WADDR_W:BIT_W+1];
	assign p_word = {{(WADDR_W - PWORD_W){1'b0}}, p_q[P_W-1:BIT_W+1]};
	assign sq_full = p_q * p_q;

	// Bitmap port selection.
	always_comb begin
		raddr = '0;
		re    = 1'b1;
		case (cmd.rd_sel)
			obps_pkg::RD_P: raddr = p_word;
			obps_pkg::RD_J: raddr = j_word;
			obps_pkg::RD_W: raddr = w_q;
			default:        re    = 1'b0;
		endcase
		we    = (cmd.wr_sel != obps_pkg::WR_NONE);
		waddr = (cmd.wr_sel == obps_pkg::WR_CLEAR) ? w_q : j_word;
		wdata = (cmd.wr_sel == obps_pkg::WR_CLEAR) ? '0 :
			(rdata_q | (WORD_BITS'(1) << j_q[BIT_W:1]));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Counting pipeline: mask the word to the odd numbers 3..L, count the clear bits.
	always_comb begin
		mask = '1;
		if (cw_s1 == hw) begin
			mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hb);
		end
		if (cw_s1 == '0) begin
			mask[0] = 1'b0;
		end
		zeros = ~rdata_q & mask;
		for (int b = 0; b < NBYTES; b++) begin
			bc[b] = obps_pkg::popcnt8(zeros[8*b +: 8]);
		end
		bsum = '0;
		for (int b = 0; b < NBYTES; b++) begin
			bsum = bsum + SUM_W'(bc_s2[b]);
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= sq_full[J_W-1:0];
		cw_s1 <= w_q;
		for (int b = 0; b < NBYTES; b++) begin
			bc_s2[b] <= bc[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= obps_pkg::CMD_SIEVE;
			j_q        <= '0;
			p_q        <= P_W'(3);
			w_q        <= '0;
			pend_q     <= 1'b0;
			pend_val_q <= '0;
			k_q        <= '0;
			cv_s1      <= 1'b0;
			cv_s2      <= 1'b0;
		end else begin
			cv_s1 <= cmd.cnt_issue;
			cv_s2 <= cv_s1;
			if (cmd.accept) begin
				cmd_q  <= req_cmd;
				j_q    <= (req_cmd == obps_pkg::CMD_LIST) ? {1'b0, lim} : {1'b0, req_number};
				p_q    <= P_W'(3);
				w_q    <= '0;
				pend_q <= 1'b0;
				k_q    <= '0;
			end else begin
				if (cmd.p_inc) begin
					p_q <= p_q + P_W'(2);
				end
				if (cmd.j_ld_sq) begin
					j_q <= sq_s1;
				end else if (cmd.j_step) begin
					j_q <= j_q + J_W'({p_q, 1'b0});
				end else if (cmd.j_dec) begin
					j_q <= j_q - J_W'(2);
				end
				if (cmd.cnt_init) begin
					w_q <= '0;
				end else if (cmd.w_inc) begin
					w_q <= w_q + WADDR_W'(1);
				end
				if (cmd.list_take) begin
					pend_q     <= 1'b1;
					pend_val_q <= cmd.take_two ? LIM_W'(2) : j_q[LIM_W-1:0];
					k_q        <= k_q + K_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			sieve_done_q <= 1'b0;
		end else begin
			if (cmd.cnt_init) begin
				cnt_q <= stat.lim_ge2 ? CNT_W'(1) : '0;
			end else if (cv_s2) begin
				cnt_q <= cnt_q + CNT_W'(bsum);
			end
			if (cfg_wr) begin
				sieve_done_q <= 1'b0;
			end else if (cmd.out_final && cmd_q == obps_pkg::CMD_SIEVE) begin
				sieve_done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		q_prime = 1'b0;
		if (j_q == J_W'(2)) begin
			q_prime = 1'b1;
		end else if (j_q >= J_W'(3) && j_q[0]) begin
			q_prime = ~stat.j_marked;
		end
	end

	// Next result: an intermediate list entry or the closing result of the request.
	always_comb begin
		nx_valid_res = 1'b1;
		nx_is_prime  = 1'b1;
		nx_value     = pend_val_q;
		nx_count     = cnt_q;
		nx_last      = 1'b0;
		if (cmd.out_final) begin
			nx_last = 1'b1;
			unique case (cmd_q)
				obps_pkg::CMD_SIEVE: begin
					nx_is_prime = 1'b0;
					nx_value    = lim;
				end
				obps_pkg::CMD_QUERY: begin
					nx_value = j_q[LIM_W-1:0];
					if (!sieve_done_q) begin
						nx_valid_res = 1'b0;
						nx_is_prime  = 1'b0;
						nx_count     = '0;
					end else if (stat.j_gt_lim) begin
						nx_valid_res = 1'b0;
						nx_is_prime  = 1'b0;
					end else begin
						nx_is_prime = q_prime;
					end
				end
				obps_pkg::CMD_LIST: begin
					if (!sieve_done_q) begin
						nx_valid_res = 1'b0;
						nx_is_prime  = 1'b0;
						nx_value     = '0;
						nx_count     = '0;
					end else if (!pend_q) begin
						nx_is_prime = 1'b0;
						nx_value    = '0;
					end
				end
				default: begin
					nx_valid_res = 1'b0;
					nx_is_prime  = 1'b0;
					nx_value     = '0;
					nx_count     = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_mid || cmd.out_final) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_mid || cmd.out_final) begin
			out_valid_res_q <= nx_valid_res;
			out_is_prime_q  <= nx_is_prime;
			out_value_q     <= nx_value;
			out_count_q     <= nx_count;
			out_last_q      <= nx_last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.valid_res   = out_valid_res_q;
	assign res.is_prime    = out_is_prime_q;
	assign res.prime_value = out_value_q;
	assign res.prime_count = out_count_q;
	assign res.last        = out_last_q;

	assign stat.sieve_done = sieve_done_q;
	assign stat.sq_gt_lim  = sq_s1 > {1'b0, lim};
	assign stat.p_marked   = rdata_q[p_q[BIT_W:1]];
	assign stat.j_gt_lim   = j_q > {1'b0, lim};
	assign stat.j_lt3      = j_q < J_W'(3);
	assign stat.j_marked   = rdata_q[j_q[BIT_W:1]];
	assign stat.w_last     = (w_q == hw);
	assign stat.cnt_busy   = cv_s1 | cv_s2;
	assign stat.out_free   = ~out_valid_q | res.ready;
	assign stat.k_last     = (k_q == K_W'(obps_pkg::LIST_LEN - 1));
	assign stat.pend       = pend_q;
	assign stat.lim_ge2    = lim >= LIM_W'(2);

endmodule

FILE: rtl/core/obps_ctrl.sv
`timescale 1ns / 1ps

module obps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_cmd,
	input  obps_pkg::dp_stat_t stat,
	output logic               req_ready,
	output obps_pkg::dp_cmd_t  cmd
);

	obps_pkg::state_t state_q;
	obps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			obps_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					unique case (req_cmd)
						obps_pkg::CMD_SIEVE: state_d = obps_pkg::ST_CLEAR;
						obps_pkg::CMD_QUERY: state_d = obps_pkg::ST_Q_RD;
						obps_pkg::CMD_LIST:  state_d = stat.sieve_done ? obps_pkg::ST_L_RD :
							obps_pkg::ST_FIN;
						default:             state_d = obps_pkg::ST_FIN;
					endcase
				end
			end
			obps_pkg::ST_CLEAR: begin
				cmd.wr_sel = obps_pkg::WR_CLEAR;
				cmd.w_inc  = 1'b1;
				if (stat.w_last) begin
					state_d = obps_pkg::ST_P_SQ;
				end
			end
			obps_pkg::ST_P_SQ: begin
				state_d = obps_pkg::ST_P_CHK;
			end
			obps_pkg::ST_P_CHK: begin
				if (stat.sq_gt_lim) begin
					cmd.cnt_init = 1'b1;
					state_d      = obps_pkg::ST_COUNT;
				end else begin
					cmd.rd_sel = obps_pkg::RD_P;
					state_d    = obps_pkg::ST_P_RD;
				end
			end
			obps_pkg::ST_P_RD: begin
				if (stat.p_marked) begin
					cmd.p_inc = 1'b1;
					state_d   = obps_pkg::ST_P_SQ;
				end else begin
					cmd.j_ld_sq = 1'b1;
					state_d     = obps_pkg::ST_M_RD;
				end
			end
			obps_pkg::ST_M_RD: begin
				if (stat.j_gt_lim) begin
					cmd.p_inc = 1'b1;
					state_d   = obps_pkg::ST_P_SQ;
				end else begin
					cmd.rd_sel = obps_pkg::RD_J;
					state_d    = obps_pkg::ST_M_WR;
				end
			end
			obps_pkg::ST_M_WR: begin
				cmd.wr_sel = obps_pkg::WR_MARK;
				cmd.j_step = 1'b1;
				state_d    = obps_pkg::ST_M_RD;
			end
			obps_pkg::ST_COUNT: begin
				cmd.rd_sel    = obps_pkg::RD_W;
				cmd.cnt_issue = 1'b1;
				cmd.w_inc     = 1'b1;
				if (stat.w_last) begin
					state_d = obps_pkg::ST_DRAIN;
				end
			end
			obps_pkg::ST_DRAIN: begin
				if (!stat.cnt_busy) begin
					state_d = obps_pkg::ST_FIN;
				end
			end
			obps_pkg::ST_Q_RD: begin
				cmd.rd_sel = obps_pkg::RD_J;
				state_d    = obps_pkg::ST_FIN;
			end
			obps_pkg::ST_L_RD: begin
				if (stat.j_lt3) begin
					state_d = obps_pkg::ST_L_TWO;
				end else begin
					cmd.rd_sel = obps_pkg::RD_J;
					state_d    = obps_pkg::ST_L_CHK;
				end
			end
			obps_pkg::ST_L_CHK: begin
				if (stat.j_marked) begin
					cmd.j_dec = 1'b1;
					state_d   = obps_pkg::ST_L_RD;
				end else if (!stat.pend || stat.out_free) begin
					cmd.list_take = 1'b1;
					cmd.out_mid   = stat.pend;
					cmd.j_dec     = 1'b1;
					state_d       = stat.k_last ? obps_pkg::ST_FIN : obps_pkg::ST_L_RD;
				end
			end
			obps_pkg::ST_L_TWO: begin
				if (!stat.lim_ge2) begin
					state_d = obps_pkg::ST_FIN;
				end else if (!stat.pend || stat.out_free) begin
					cmd.list_take = 1'b1;
					cmd.take_two  = 1'b1;
					cmd.out_mid   = stat.pend;
					state_d       = obps_pkg::ST_FIN;
				end
			end
			obps_pkg::ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_final = 1'b1;
					state_d       = obps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = obps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/odd_bitmap_prime_sieve.sv
// Odd-only prime sieve over a 8192 x 64-bit bitmap, one bit per odd number.
// Requests arrive on req (cmd, number) and results leave on res; both use a
// valid/ready handshake. The APB port holds the limit register at address 0.
// A sieve request clears the bitmap words up to the limit, marks odd
// multiples with a read-modify-write per mark (a read state, then a write
// state), then counts the primes one word per cycle; it returns one result.
// A query reads the bitmap word of its number and returns one result. A
// list request scans downward over the odd candidates, reading each one,
// and returns up to ten primes, largest first, with last set on the final
// one.
// A new request is taken whenever the controller is idle, even while the last
// result still waits in the output register. When the receiver stalls, the
// result is held and the block waits before writing the next one.
// Reset sets the limit to 1000 and marks no sieve as done; queries and lists
// then return an invalid result until a sieve has run. Writing the limit
// also invalidates the last sieve.
`timescale 1ns / 1ps

module odd_bitmap_prime_sieve (
	input  logic                        clk,
	input  logic                        arst_n,
	obps_req_if.sink                    req,
	obps_res_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [obps_pkg::APB_AW-1:0] paddr,
	input  logic [obps_pkg::APB_DW-1:0] pwdata,
	output logic [obps_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	logic [obps_pkg::LIM_W-1:0] lim;
	logic                       cfg_wr;
	logic                       ctrl_ready;
	obps_pkg::dp_cmd_t          dp_cmd;
	obps_pkg::dp_stat_t         dp_stat;

	assign req.ready = ctrl_ready;

	obps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lim     (lim),
		.wr      (cfg_wr)
	);

	obps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.stat      (dp_stat),
		.req_ready (ctrl_ready),
		.cmd       (dp_cmd)
	);

	obps_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.req_cmd    (req.cmd),
		.req_number (req.number),
		.lim        (lim),
		.cfg_wr     (cfg_wr),
		.res        (res)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.out_mid || dp_cmd.out_final) |-> dp_stat.out_free)
		else $error("result register overwritten while still held");

	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.list_take |-> (!dp_stat.pend || dp_stat.out_free))
		else $error("pending list entry dropped");

	a_cfg_invalidates: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !dp_stat.sieve_done)
		else $error("sieve still marked done after a limit write");

	a_prime_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.is_prime) |-> res.valid_res)
		else $error("prime reported without a completed sieve");

endmodule

FILE: verif/tb_odd_bitmap_prime_sieve.sv
`timescale 1ns / 1ps

module tb_odd_bitmap_prime_sieve;

	typedef struct packed {
		logic                       valid_res;
		logic                       is_prime;
		logic [obps_pkg::LIM_W-1:0] prime_value;
		logic [obps_pkg::CNT_W-1:0] prime_count;
		logic                       last;
	} answer_t;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [obps_pkg::LIM_W-1:0] number;
	} request_t;

	localparam logic [1:0] CMD_UNDEF = 2'd3;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [obps_pkg::APB_AW-1:0] paddr;
	logic [obps_pkg::APB_DW-1:0] pwdata;
	logic [obps_pkg::APB_DW-1:0] prdata;
	logic pready;

	obps_req_if req_ch();
	obps_res_if res_ch();

	odd_bitmap_prime_sieve dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	bit composite_odd [0:obps_pkg::MAX_LIMIT/2-1];
	logic [obps_pkg::LIM_W-1:0] limit_mirror;
	bit sieved;
	logic [obps_pkg::CNT_W-1:0] prime_tally;

	answer_t answer_q[$];
	request_t request_q[$];
	int queued_count;
	int accepted_count;
	int mismatches;
	int send_gap;
	int sink_stall;
	int sink_hold_left;
	logic sink_hold_kick;
	logic idle_on;

	always #1 clk = ~clk;

	task automatic solve_request(input logic [1:0] cmd,
		input logic [obps_pkg::LIM_W-1:0] number);
		int unsigned bound;
		int unsigned i;
		int unsigned j;
		int unsigned cnt;
		int k;
		bit prime;
		bound = limit_mirror;
		if (bound % 2 == 0 && bound != 0)
			bound--;
		case (cmd)
			obps_pkg::CMD_SIEVE: begin
				for (i = 0; i <= bound / 2; i++)
					composite_odd[i] = 1'b0;
				for (i = 3; i * i <= bound; i += 2) begin
					if (!composite_odd[i >> 1]) begin
						for (j = i * i; j <= bound; j += 2 * i)
							composite_odd[j >> 1] = 1'b1;
					end
				end
				cnt = (bound >= 2) ? 1 : 0;
				for (i = 3; i <= bound; i += 2) begin
					if (!composite_odd[i >> 1])
						cnt++;
				end
				prime_tally = obps_pkg::CNT_W'(cnt);
				sieved = 1'b1;
				answer_q.push_back('{1'b1, 1'b0, obps_pkg::LIM_W'(bound), prime_tally, 1'b1});
			end
			obps_pkg::CMD_QUERY: begin
				if (!sieved) begin
					answer_q.push_back('{1'b0, 1'b0, number, '0, 1'b1});
				end else if (number > bound) begin
					answer_q.push_back('{1'b0, 1'b0, number, prime_tally, 1'b1});
				end else begin
					prime = (number == 2) ||
						(number >= 3 && number[0] && !composite_odd[number >> 1]);
					answer_q.push_back('{1'b1, prime, number, prime_tally, 1'b1});
				end
			end
			obps_pkg::CMD_LIST: begin
				if (!sieved) begin
					answer_q.push_back('{1'b0, 1'b0, '0, '0, 1'b1});
				end else begin
					k = 0;
					for (i = bound; i >= 3 && k < obps_pkg::LIST_LEN; i -= 2) begin
						if (!composite_odd[i >> 1]) begin
							answer_q.push_back('{1'b1, 1'b1, obps_pkg::LIM_W'(i),
								prime_tally, 1'b0});
							k++;
						end
					end
					if (k < obps_pkg::LIST_LEN && bound >= 2) begin
						answer_q.push_back('{1'b1, 1'b1, obps_pkg::LIM_W'(2),
							prime_tally, 1'b0});
						k++;
					end
					if (k == 0)
						answer_q.push_back('{1'b1, 1'b0, '0, prime_tally, 1'b1});
					else
						answer_q[$].last = 1'b1;
				end
			end
			default: begin
				answer_q.push_back('{1'b0, 1'b0, '0, '0, 1'b1});
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_t next_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= obps_pkg::CMD_SIEVE;
			req_ch.number <= '0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				solve_request(req_ch.cmd, req_ch.number);
				accepted_count++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					next_req = request_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= next_req.cmd;
					req_ch.number <= next_req.number;
					if (idle_on && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 9);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t seen;
		answer_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				seen = {res_ch.valid_res, res_ch.is_prime, res_ch.prime_value,
					res_ch.prime_count, res_ch.last};
				if (answer_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: valid_res=%0d is_prime=%0d value=%0d count=%0d last=%0d",
							seen.valid_res, seen.is_prime, seen.prime_value,
							seen.prime_count, seen.last);
				end else begin
					want = answer_q.pop_front();
					if (seen.valid_res !== want.valid_res || seen.is_prime !== want.is_prime ||
						seen.prime_value !== want.prime_value ||
						seen.prime_count !== want.prime_count || seen.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected valid_res=%0d is_prime=%0d value=%0d count=%0d last=%0d",
								want.valid_res, want.is_prime, want.prime_value,
								want.prime_count, want.last);
							$display("          actual   valid_res=%0d is_prime=%0d value=%0d count=%0d last=%0d",
								seen.valid_res, seen.is_prime, seen.prime_value,
								seen.prime_count, seen.last);
						end
					end
				end
			end
			if (sink_stall > 0)
				sink_stall--;
			else if (idle_on && $urandom_range(0, 4) == 0)
				sink_stall = $urandom_range(1, 9);
			res_ch.ready <= (sink_stall == 0) && (sink_hold_left == 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sink_hold_left <= 0;
		else if (sink_hold_kick)
			sink_hold_left <= 400;
		else if (sink_hold_left != 0)
			sink_hold_left <= sink_hold_left - 1;
	end

	task automatic push_request(input logic [1:0] cmd,
		input logic [obps_pkg::LIM_W-1:0] number);
		request_q.push_back('{cmd, number});
		queued_count++;
	endtask

	task automatic drain();
		while (accepted_count != queued_count || answer_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(input logic [obps_pkg::LIM_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= obps_pkg::REG_LIMIT;
		pwdata <= obps_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[obps_pkg::LIM_W-1:0] !== value) begin
			mismatches++;
			if (mismatches <= 10)
				$display("limit readback: expected %0d, actual %0d", value,
					prdata[obps_pkg::LIM_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		limit_mirror = value;
		sieved = 1'b0;
	endtask

	initial begin
		#40_000_000;
		$display("FAIL odd_bitmap_prime_sieve");
		$finish;
	end

	initial begin
		int rand_items;
		int phase;
		int n;
		int r;
		logic [obps_pkg::LIM_W-1:0] lim;
		logic [obps_pkg::LIM_W-1:0] bound;
		logic [obps_pkg::LIM_W-1:0] num;

		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = obps_pkg::CMD_SIEVE;
		req_ch.number = '0;
		res_ch.ready = 1'b0;
		sink_hold_kick = 1'b0;
		idle_on = 1'b1;
		queued_count = 0;
		accepted_count = 0;
		mismatches = 0;
		limit_mirror = obps_pkg::LIMIT_RESET;
		sieved = 1'b0;
		prime_tally = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset limit of 1000, then requests before and after the first sieve.
		push_request(obps_pkg::CMD_QUERY, 20'd7);
		push_request(obps_pkg::CMD_LIST, 20'd0);
		push_request(CMD_UNDEF, 20'hFFFFF);
		push_request(obps_pkg::CMD_SIEVE, 20'hFFFFF);
		push_request(obps_pkg::CMD_QUERY, 20'd997);
		push_request(obps_pkg::CMD_QUERY, 20'd2);
		push_request(obps_pkg::CMD_QUERY, 20'd0);
		push_request(obps_pkg::CMD_QUERY, 20'd1);
		push_request(obps_pkg::CMD_QUERY, 20'd4);
		push_request(obps_pkg::CMD_QUERY, 20'd1001);
		push_request(obps_pkg::CMD_QUERY, 20'hFFFFF);
		push_request(obps_pkg::CMD_LIST, 20'd0);
		drain();

		set_limit(20'd29);
		push_request(obps_pkg::CMD_LIST, 20'd0);
		push_request(obps_pkg::CMD_SIEVE, 20'd0);
		push_request(obps_pkg::CMD_LIST, 20'd0);
		push_request(obps_pkg::CMD_QUERY, 20'd29);
		push_request(obps_pkg::CMD_QUERY, 20'd30);
		drain();

		set_limit(20'd30);
		push_request(obps_pkg::CMD_SIEVE, 20'd0);
		push_request(obps_pkg::CMD_QUERY, 20'd29);
		drain();

		set_limit(20'hFFFFF);
		push_request(obps_pkg::CMD_SIEVE, 20'd0);
		push_request(obps_pkg::CMD_LIST, 20'd0);
		push_request(obps_pkg::CMD_QUERY, 20'hFFFFF);
		push_request(obps_pkg::CMD_QUERY, 20'hFFFFE);
		push_request(obps_pkg::CMD_QUERY, 20'd1048573);
		drain();

		rand_items = 0;
		phase = 0;
		while (rand_items < 76) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				lim = obps_pkg::LIM_W'($urandom_range(3001, 40000));
			else if (r == 1)
				lim = obps_pkg::LIM_W'($urandom_range(29, 30));
			else
				lim = obps_pkg::LIM_W'($urandom_range(29, 3000));
			bound = lim[0] ? lim : lim - 1;
			set_limit(lim);
			if ($urandom_range(0, 4) == 0) begin
				push_request(obps_pkg::CMD_QUERY, obps_pkg::LIM_W'($urandom_range(0, bound)));
				rand_items++;
			end
			push_request(obps_pkg::CMD_SIEVE, obps_pkg::LIM_W'($urandom));
			rand_items++;
			n = $urandom_range(4, 12);
			repeat (n) begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					push_request(CMD_UNDEF, obps_pkg::LIM_W'($urandom));
				end else if (r == 1) begin
					push_request(obps_pkg::CMD_SIEVE, obps_pkg::LIM_W'($urandom));
				end else if (r <= 4) begin
					push_request(obps_pkg::CMD_LIST, obps_pkg::LIM_W'($urandom));
				end else begin
					r = $urandom_range(0, 9);
					if (r <= 5)
						num = obps_pkg::LIM_W'($urandom_range(0, bound));
					else if (r <= 7)
						num = obps_pkg::LIM_W'($urandom_range(0, bound)) | obps_pkg::LIM_W'(1);
					else if (r == 8)
						num = obps_pkg::LIM_W'($urandom);
					else
						num = bound - obps_pkg::LIM_W'($urandom_range(0, 20));
					push_request(obps_pkg::CMD_QUERY, num);
				end
				rand_items++;
			end
			drain();

			if (phase == 1) begin
				@(posedge clk);
				sink_hold_kick <= 1'b1;
				@(posedge clk);
				sink_hold_kick <= 1'b0;
				repeat (8) begin
					push_request(obps_pkg::CMD_LIST, obps_pkg::LIM_W'($urandom));
					push_request(obps_pkg::CMD_QUERY,
						obps_pkg::LIM_W'($urandom_range(0, bound)));
					rand_items += 2;
				end
				drain();
			end

			phase++;
			if (rand_items >= 60) begin
				@(posedge clk);
				idle_on <= 1'b0;
			end
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("PASS odd_bitmap_prime_sieve");
		end else begin
			$display("FAIL odd_bitmap_prime_sieve");
		end
		$finish;
	end

endmodule
